>>> rtl/rsa_pkg.sv
// Shared types, codes and defaults of the ring staging allocator.
package rsa_pkg;

    localparam int DEF_OFFSET_WIDTH = 32;
    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam logic [31:0] CAPACITY_RESET = 32'd65536;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_IMAGE   = 2'd1,
        MODE_RETIRE  = 2'd2,
        MODE_COLLECT = 2'd3
    } mode_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_RESTARTED = 3'd3;
    localparam logic [2:0] ST_Q_FULL    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_PLACE, S_RETIRE, S_CRD, S_CCHK, S_CEND, S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic place;
        logic retire;
        logic q_rd;
        logic pop;
        logic coll_end;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  q_empty;
        logic  pop_ok;
        logic  out_free;
    } sts_t;

endpackage

>>> rtl/rsa_ctrl.sv
// Controller state machine of the ring staging allocator.
module rsa_ctrl import rsa_pkg::*; #(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_accept,
    input  sts_t sts,
    output cmd_t cmd,
    output logic idle
);

    localparam int NW = $clog2(OFFSET_WIDTH + 1);

    state_t state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    // Hold state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequence one transaction through its steps
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        idle       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                idle = 1'b1;
                if (in_accept) begin
                    cmd.load = 1'b1;
                    unique case (sts.mode)
                        MODE_ALLOC, MODE_IMAGE: begin
                            state_next = S_DIV;
                            cnt_next   = NW'(OFFSET_WIDTH);
                        end
                        MODE_RETIRE:  state_next = S_RETIRE;
                        MODE_COLLECT: state_next = S_CRD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == NW'(1)) state_next = S_PLACE;
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_RETIRE: begin
                cmd.retire = 1'b1;
                state_next = S_DONE;
            end
            S_CRD: begin
                if (sts.q_empty) begin
                    state_next = S_CEND;
                end else begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_CCHK;
                end
            end
            S_CCHK: begin
                if (sts.pop_ok) begin
                    cmd.pop    = 1'b1;
                    state_next = S_CRD;
                end else begin
                    state_next = S_CEND;
                end
            end
            S_CEND: begin
                cmd.coll_end = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/rsa_datapath.sv
// Datapath of the ring staging allocator: ring state, remainder unit, span queue.
module rsa_datapath import rsa_pkg::*; #(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic [1:0]   in_mode,
    input  logic [223:0] in_data,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [71:0]  m_tdata,
    output logic [0:0]   m_tuser
);

    localparam int OW = OFFSET_WIDTH;
    localparam int EW = OFFSET_WIDTH + 34;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]   cap_reg;
    logic [OW-1:0] head_reg, tail_reg, pbeg_reg, pend_reg;
    logic          pv_reg;
    logic [PW-1:0] rptr_reg, wptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   size_reg, align_reg;
    logic [63:0]   fence_reg;
    logic [32:0]   rem_reg;
    logic [OW-1:0] dvd_reg;
    logic [OW-1:0] qend_mem [QUEUE_DEPTH];
    logic [63:0]   qfence_mem [QUEUE_DEPTH];
    logic [OW-1:0] rd_end_reg;
    logic [63:0]   rd_fence_reg;
    logic          res_granted_reg;
    logic [31:0]   res_offset_reg, res_size_reg;
    logic [2:0]    res_status_reg;
    logic [4:0]    res_freed_reg;
    logic          m_valid_reg;
    logic [71:0]   m_data_reg;
    logic          m_user_reg;

    // Unpack input fields
    logic [31:0] in_size, in_align, in_texel, in_pitch, in_palign;
    logic [63:0] in_fence;
    assign in_size   = in_data[31:0];
    assign in_align  = in_data[63:32];
    assign in_texel  = in_data[95:64];
    assign in_pitch  = in_data[127:96];
    assign in_palign = in_data[159:128];
    assign in_fence  = in_data[223:160];

    // Pick the effective alignment, never zero
    logic [31:0] a_base, a_pitch, a_eff;
    always_comb begin
        a_base  = (in_align > 32'd1) ? in_align : 32'd1;
        a_pitch = (in_pitch != 32'd0 && in_palign > a_base) ? in_palign : a_base;
        if (in_mode == MODE_IMAGE) begin
            a_eff = (in_texel > a_pitch) ? in_texel : a_pitch;
        end else begin
            a_eff = a_base;
        end
    end

    // Limit capacity to the offset range
    logic [EW-1:0] cap_lim, cap_ext, cap_eff;
    assign cap_lim = (EW'(1) << OW) - EW'(1);
    assign cap_ext = EW'(cap_reg);
    assign cap_eff = (cap_ext < cap_lim) ? cap_ext : cap_lim;

    // One restoring remainder step
    logic [32:0] rem_sh, rem_step;
    assign rem_sh   = {rem_reg[31:0], dvd_reg[OW-1]};
    assign rem_step = (rem_sh >= {1'b0, align_reg}) ? rem_sh - {1'b0, align_reg} : rem_sh;

    // Place the range at the aligned tail or at zero
    logic [EW-1:0] tail_e, head_e, size_e, begin_al, end_al, begin_g, end_g;
    logic          full, size_fits, ok1, ok2;
    always_comb begin
        tail_e    = EW'(tail_reg);
        head_e    = EW'(head_reg);
        size_e    = EW'(size_reg);
        begin_al  = (rem_reg == 33'd0) ? tail_e
                  : tail_e + EW'(align_reg) - EW'(rem_reg);
        end_al    = begin_al + size_e;
        full      = (head_reg == tail_reg) && (pv_reg || cnt_reg != '0);
        size_fits = (size_e <= cap_eff) && !full;
        if (head_reg > tail_reg) begin
            ok1 = size_fits && end_al <= head_e && end_al <= cap_eff;
        end else begin
            ok1 = size_fits && end_al <= cap_eff;
        end
        ok2     = !ok1 && size_fits && (head_reg <= tail_reg) && size_e <= head_e;
        begin_g = ok1 ? begin_al : '0;
        end_g   = begin_g + size_e;
    end

    // Advance queue pointers
    logic [PW-1:0] rptr_inc, wptr_inc;
    assign rptr_inc = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
    assign wptr_inc = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;

    // Update ring and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAPACITY_RESET;
            head_reg <= '0;
            tail_reg <= '0;
            pbeg_reg <= '0;
            pend_reg <= '0;
            pv_reg   <= 1'b0;
            rptr_reg <= '0;
            wptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
            if (cmd.place && size_reg != 32'd0 && (ok1 || ok2)) begin
                tail_reg <= end_g[OW-1:0];
                if (!pv_reg || begin_g < EW'(pbeg_reg)) begin
                    pbeg_reg <= begin_g[OW-1:0];
                    pend_reg <= end_g[OW-1:0];
                    pv_reg   <= 1'b1;
                end else if (end_g > EW'(pend_reg)) begin
                    pend_reg <= end_g[OW-1:0];
                end
            end
            if (cmd.retire && fence_reg != 64'd0 && pv_reg
                    && cnt_reg != CW'(QUEUE_DEPTH)) begin
                wptr_reg <= wptr_inc;
                cnt_reg  <= cnt_reg + 1'b1;
                pv_reg   <= 1'b0;
                pbeg_reg <= '0;
                pend_reg <= '0;
            end
            if (cmd.pop) begin
                head_reg <= (EW'(rd_end_reg) >= cap_eff) ? '0 : rd_end_reg;
                rptr_reg <= rptr_inc;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            if (cmd.coll_end && cnt_reg == '0 && !pv_reg) head_reg <= tail_reg;
        end
    end

    // Capture the transaction and run the remainder unit
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            size_reg  <= in_size;
            align_reg <= a_eff;
            fence_reg <= in_fence;
            rem_reg   <= '0;
            dvd_reg   <= tail_reg;
        end else if (cmd.div_step) begin
            rem_reg <= rem_step;
            dvd_reg <= {dvd_reg[OW-2:0], 1'b0};
        end
    end

    // Write and read the span queue
    always_ff @(posedge aclk) begin
        if (cmd.retire && fence_reg != 64'd0 && pv_reg && cnt_reg != CW'(QUEUE_DEPTH)) begin
            qend_mem[wptr_reg]   <= pend_reg;
            qfence_mem[wptr_reg] <= fence_reg;
        end
        if (cmd.q_rd) begin
            rd_end_reg   <= qend_mem[rptr_reg];
            rd_fence_reg <= qfence_mem[rptr_reg];
        end
    end

    // Build the result fields
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_granted_reg <= 1'b0;
            res_offset_reg  <= '0;
            res_size_reg    <= '0;
            res_status_reg  <= ST_OK;
            res_freed_reg   <= '0;
        end
        if (cmd.place) begin
            if (size_reg == 32'd0) begin
                res_status_reg <= ST_IGNORED;
            end else if (!(ok1 || ok2)) begin
                res_status_reg <= ST_NO_SPACE;
            end else begin
                res_granted_reg <= 1'b1;
                res_offset_reg  <= begin_g[31:0];
                res_size_reg    <= size_reg;
                res_status_reg  <= (pv_reg && begin_g < EW'(pbeg_reg)) ? ST_RESTARTED : ST_OK;
            end
        end
        if (cmd.retire) begin
            if (fence_reg == 64'd0 || !pv_reg) begin
                res_status_reg <= ST_IGNORED;
            end else if (cnt_reg == CW'(QUEUE_DEPTH)) begin
                res_status_reg <= ST_Q_FULL;
            end
        end
        if (cmd.pop && res_freed_reg != 5'd31) res_freed_reg <= res_freed_reg + 1'b1;
    end

    // Hold the result transaction until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {res_freed_reg, res_status_reg, res_size_reg, res_offset_reg};
            m_user_reg <= res_granted_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Report status to the controller; the mode is only looked at on acceptance
    always_comb begin
        sts.mode     = mode_t'(in_mode);
        sts.q_empty  = (cnt_reg == '0);
        sts.pop_ok   = (rd_fence_reg <= fence_reg);
        sts.out_free = !m_valid_reg || m_tready;
    end

endmodule

>>> rtl/ring_staging_allocator.sv
// Top level of the ring staging allocator.
// Ring buffer allocator: each input transaction (allocate, image allocate, retire or
// collect) yields exactly one result transaction. An allocation first runs the
// bit-serial remainder unit that aligns the tail and then places the range; a retire
// queues the open span; a collect reads the span queue and compares the fence of each
// span in turn, releasing spans until the queue is empty or it stops at a span whose
// fence has not yet completed. One transaction is in work at a time; the next is taken
// while the previous result still waits on the output register, and a finished result
// waits in its last step for as long as that register stays full. No transaction is
// taken during reset.
module ring_staging_allocator import rsa_pkg::*; #(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,     // capacity_bytes
    input  logic         s_tvalid,
    output logic         s_tready,
    // size_bytes, alignment, texel_block_bytes, row_pitch_bytes,
    // row_pitch_alignment, fence_value
    input  logic [223:0] s_tdata,
    input  logic [1:0]   s_tuser,         // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,         // offset, granted_size, status, freed_spans
    output logic [0:0]   m_tuser          // granted
);

    cmd_t cmd;
    sts_t sts;
    logic idle;

    assign s_tready = idle && aresetn;

    rsa_ctrl #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && s_tready),
        .sts       (sts),
        .cmd       (cmd),
        .idle      (idle)
    );

    rsa_datapath #(
        .OFFSET_WIDTH(OFFSET_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mode     (s_tuser),
        .in_data     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
